@@ rtl/lzfd_pkg.sv @@
`default_nettype none

package lzfd_pkg;

  localparam int unsigned HISTORY_DEPTH = 4096;
  localparam int unsigned ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int unsigned CNT_W         = ADDR_W + 1;
  localparam int unsigned LEN_W         = 5;

  localparam logic [LEN_W-1:0] LEN_BIAS   = LEN_W'(3);
  localparam logic [8:0]       FLAG_EMPTY = 9'h001;

  // end-of-stream status codes
  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_TRUNC  = 2'd1;
  localparam logic [1:0] STATUS_BEFORE = 2'd2;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_COPY,
    ST_STATUS
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       load_flag;
    logic       shift_flag;
    logic       take_first;
    logic       take_second;
    logic       set_before;
    logic       start_copy;
    logic       copy_en;
    logic       push_lit;
    logic       lit_last;
    logic       emit_status;
    logic [1:0] status_code;
    logic       clear_stream;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       out_free;
    logic       err_nz;
    logic [1:0] err_code;
    logic       flag_empty;
    logic       flag_lsb;
    logic       awaiting;
    logic       too_far;
    logic       copy_idle;
    logic       last_q;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/lzfd_if.sv @@
`default_nettype none

// compressed byte channel
interface lzfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_last;

  modport source (output valid, output in_byte, output is_last, input ready);
  modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// result channel
interface lzfd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_status;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output out_byte, output is_status, output status,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input is_status, input status,
                  input last_of_run, output ready);
endinterface

// configuration write channel
interface lzfd_cfg_if;
  logic valid;
  logic ready;
  logic swap_nibbles;

  modport source (output valid, output swap_nibbles, input ready);
  modport sink   (input valid, input swap_nibbles, output ready);
endinterface

`default_nettype wire

@@ rtl/lzfd_ram.sv @@
`default_nettype none

module lzfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/lzfd_datapath.sv @@
`default_nettype none

module lzfd_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        in_byte_i,
  input  wire logic              in_last_i,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_swap_i,
  input  wire lzfd_pkg::dp_cmd_t cmd_i,
  output lzfd_pkg::dp_stat_t     stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [7:0]             out_byte_o,
  output logic                   out_is_status_o,
  output logic [1:0]             out_status_o,
  output logic                   out_last_o
);

  localparam int unsigned AW = lzfd_pkg::ADDR_W;
  localparam int unsigned CW = lzfd_pkg::CNT_W;
  localparam int unsigned LW = lzfd_pkg::LEN_W;

  logic          swap_q, swap_d;
  logic [8:0]    flag_q, flag_d;
  logic          await_q, await_d;
  logic [7:0]    first_q, first_d;
  logic [1:0]    err_q, err_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [CW-1:0] count_q, count_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [LW-1:0] issue_left_q, issue_left_d;
  logic [LW-1:0] done_left_q, done_left_d;
  logic          pend_q, pend_d;
  logic          last_q, last_d;
  logic          fwd_q, fwd_d;
  logic [7:0]    fwd_data_q, fwd_data_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_is_status_q, out_is_status_d;
  logic [1:0]    out_status_q, out_status_d;
  logic          out_last_q, out_last_d;

  logic [7:0]    b1;
  logic [AW-1:0] dist_m1;
  logic          too_far;
  logic [LW-1:0] len;
  logic          out_free;
  logic          load;
  logic          issue;
  logic [7:0]    ram_rdata;
  logic [7:0]    copy_data;
  logic          we;
  logic [7:0]    wdata;

  // token decode from the held first byte and the incoming second byte
  assign b1       = swap_q ? {first_q[3:0], first_q[7:4]} : first_q;
  assign dist_m1  = {b1[7:4], in_byte_i};
  assign too_far  = {1'b0, dist_m1} >= count_q;
  assign len      = {1'b0, b1[3:0]} + lzfd_pkg::LEN_BIAS;

  // copy pipeline: a read is issued, then the byte is written to history and shown once the result register is free
  assign out_free  = !out_valid_q || out_ready_i;
  assign load      = pend_q && out_free;
  assign issue     = cmd_i.copy_en && (issue_left_q != '0) && (!pend_q || load);
  assign copy_data = fwd_q ? fwd_data_q : ram_rdata;
  assign we        = cmd_i.push_lit || load;
  assign wdata     = load ? copy_data : in_byte_i;

  lzfd_ram #(
    .WIDTH (8),
    .DEPTH (lzfd_pkg::HISTORY_DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rp_q),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    swap_d          = cfg_we_i ? cfg_swap_i : swap_q;
    flag_d          = flag_q;
    await_d         = await_q;
    first_d         = first_q;
    err_d           = err_q;
    wp_d            = wp_q;
    count_d         = count_q;
    rp_d            = rp_q;
    issue_left_d    = issue_left_q;
    done_left_d     = done_left_q;
    pend_d          = pend_q;
    last_d          = last_q;
    fwd_d           = fwd_q;
    fwd_data_d      = fwd_data_q;
    out_byte_d      = out_byte_q;
    out_is_status_d = out_is_status_q;
    out_status_d    = out_status_q;
    out_last_d      = out_last_q;

    if (cmd_i.load_flag) begin
      flag_d = {1'b1, in_byte_i};
    end
    if (cmd_i.shift_flag) begin
      flag_d = {1'b0, flag_q[8:1]};
    end
    if (cmd_i.take_first) begin
      first_d = in_byte_i;
      await_d = 1'b1;
    end
    if (cmd_i.take_second) begin
      first_d = '0;
      await_d = 1'b0;
    end
    if (cmd_i.set_before) begin
      err_d = lzfd_pkg::STATUS_BEFORE;
    end
    if (cmd_i.start_copy) begin
      rp_d         = wp_q - dist_m1 - AW'(1);
      issue_left_d = len;
      done_left_d  = len;
      last_d       = in_last_i;
    end

    if (issue) begin
      rp_d         = rp_q + AW'(1);
      issue_left_d = issue_left_q - LW'(1);
      fwd_d        = we && (wp_q == rp_q);
      fwd_data_d   = wdata;
    end
    pend_d = issue ? 1'b1 : (load ? 1'b0 : pend_q);
    if (load) begin
      done_left_d = done_left_q - LW'(1);
    end

    if (we) begin
      wp_d = wp_q + AW'(1);
      if (count_q < CW'(lzfd_pkg::HISTORY_DEPTH)) begin
        count_d = count_q + CW'(1);
      end
    end

    if (cmd_i.clear_stream) begin
      flag_d  = lzfd_pkg::FLAG_EMPTY;
      await_d = 1'b0;
      first_d = '0;
      err_d   = lzfd_pkg::STATUS_OK;
      wp_d    = '0;
      count_d = '0;
    end

    // single result slot
    if (load) begin
      out_byte_d      = copy_data;
      out_is_status_d = 1'b0;
      out_status_d    = lzfd_pkg::STATUS_OK;
      out_last_d      = (done_left_q == LW'(1)) && !last_q;
    end else if (cmd_i.push_lit) begin
      out_byte_d      = in_byte_i;
      out_is_status_d = 1'b0;
      out_status_d    = lzfd_pkg::STATUS_OK;
      out_last_d      = cmd_i.lit_last;
    end else if (cmd_i.emit_status) begin
      out_byte_d      = '0;
      out_is_status_d = 1'b1;
      out_status_d    = cmd_i.status_code;
      out_last_d      = 1'b1;
    end
    out_valid_d = (load || cmd_i.push_lit || cmd_i.emit_status) ? 1'b1 :
                  (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q       <= 1'b0;
      flag_q       <= lzfd_pkg::FLAG_EMPTY;
      await_q      <= 1'b0;
      first_q      <= '0;
      err_q        <= lzfd_pkg::STATUS_OK;
      wp_q         <= '0;
      count_q      <= '0;
      issue_left_q <= '0;
      done_left_q  <= '0;
      pend_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      swap_q       <= swap_d;
      flag_q       <= flag_d;
      await_q      <= await_d;
      first_q      <= first_d;
      err_q        <= err_d;
      wp_q         <= wp_d;
      count_q      <= count_d;
      issue_left_q <= issue_left_d;
      done_left_q  <= done_left_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q            <= rp_d;
    last_q          <= last_d;
    fwd_q           <= fwd_d;
    fwd_data_q      <= fwd_data_d;
    out_byte_q      <= out_byte_d;
    out_is_status_q <= out_is_status_d;
    out_status_q    <= out_status_d;
    out_last_q      <= out_last_d;
  end

  always_comb begin
    stat_o.out_free   = out_free;
    stat_o.err_nz     = err_q != lzfd_pkg::STATUS_OK;
    stat_o.err_code   = err_q;
    stat_o.flag_empty = flag_q == lzfd_pkg::FLAG_EMPTY;
    stat_o.flag_lsb   = flag_q[0];
    stat_o.awaiting   = await_q;
    stat_o.too_far    = too_far;
    stat_o.copy_idle  = done_left_q == '0;
    stat_o.last_q     = last_q;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_is_status_o = out_is_status_q;
  assign out_status_o    = out_status_q;
  assign out_last_o      = out_last_q;

`ifndef SYNTH
  // reads are never ahead of the bytes still to be written
  a_issue_le_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_left_q <= done_left_q)
    else $error("copy read count ran ahead of write count");

  // a copied byte never collides with a literal or a status in the result slot
  a_slot_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(load && (cmd_i.push_lit || cmd_i.emit_status)))
    else $error("result slot loaded from two sources");

  // end of stream leaves a fresh stream behind
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_stream |=> (flag_q == lzfd_pkg::FLAG_EMPTY) && (count_q == '0)
                           && (wp_q == '0) && !await_q)
    else $error("stream state not cleared");

  // produced count saturates at the history depth
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(lzfd_pkg::HISTORY_DEPTH))
    else $error("produced count beyond history depth");
`endif

endmodule

`default_nettype wire

@@ rtl/lzfd_ctrl.sv @@
`default_nettype none

module lzfd_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  input  wire lzfd_pkg::dp_stat_t stat_i,
  output lzfd_pkg::dp_cmd_t       cmd_o
);

  lzfd_pkg::ctrl_state_e state_q, state_d;
  logic fire;

  assign in_ready_o = (state_q == lzfd_pkg::ST_ACCEPT) && stat_i.out_free;
  assign fire       = in_valid_i && in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lzfd_pkg::ST_ACCEPT: begin
        if (fire && !stat_i.err_nz && !stat_i.flag_empty) begin
          if (stat_i.awaiting) begin
            if (!stat_i.too_far) begin
              state_d = lzfd_pkg::ST_COPY;
            end
          end else if (!stat_i.flag_lsb && in_last_i) begin
            state_d = lzfd_pkg::ST_STATUS;
          end
        end
      end
      lzfd_pkg::ST_COPY: begin
        if (stat_i.copy_idle) begin
          state_d = stat_i.last_q ? lzfd_pkg::ST_STATUS : lzfd_pkg::ST_ACCEPT;
        end
      end
      lzfd_pkg::ST_STATUS: begin
        if (stat_i.out_free) begin
          state_d = lzfd_pkg::ST_ACCEPT;
        end
      end
      default: state_d = lzfd_pkg::ST_ACCEPT;
    endcase
  end

  // commands
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      lzfd_pkg::ST_ACCEPT: begin
        if (fire) begin
          if (stat_i.err_nz) begin
            // bytes are dropped until the end of the stream
            if (in_last_i) begin
              cmd_o.emit_status  = 1'b1;
              cmd_o.status_code  = stat_i.err_code;
              cmd_o.clear_stream = 1'b1;
            end
          end else if (stat_i.flag_empty) begin
            cmd_o.load_flag = 1'b1;
            if (in_last_i) begin
              cmd_o.emit_status  = 1'b1;
              cmd_o.status_code  = lzfd_pkg::STATUS_OK;
              cmd_o.clear_stream = 1'b1;
            end
          end else if (stat_i.awaiting) begin
            cmd_o.shift_flag  = 1'b1;
            cmd_o.take_second = 1'b1;
            if (stat_i.too_far) begin
              cmd_o.set_before = 1'b1;
              if (in_last_i) begin
                cmd_o.emit_status  = 1'b1;
                cmd_o.status_code  = lzfd_pkg::STATUS_BEFORE;
                cmd_o.clear_stream = 1'b1;
              end
            end else begin
              cmd_o.start_copy = 1'b1;
            end
          end else if (stat_i.flag_lsb) begin
            cmd_o.take_first = 1'b1;
            if (in_last_i) begin
              cmd_o.emit_status  = 1'b1;
              cmd_o.status_code  = lzfd_pkg::STATUS_TRUNC;
              cmd_o.clear_stream = 1'b1;
            end
          end else begin
            cmd_o.push_lit   = 1'b1;
            cmd_o.lit_last   = !in_last_i;
            cmd_o.shift_flag = 1'b1;
          end
        end
      end
      lzfd_pkg::ST_COPY: begin
        cmd_o.copy_en = 1'b1;
      end
      lzfd_pkg::ST_STATUS: begin
        if (stat_i.out_free) begin
          cmd_o.emit_status  = 1'b1;
          cmd_o.status_code  = stat_i.err_code;
          cmd_o.clear_stream = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lzfd_pkg::ST_ACCEPT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lzss_flag_byte_decoder_core.sv @@
// lzss decoder, flag bytes, 12-bit distance, 4-bit length
// in_i: compressed words, one byte each, is_last on the final byte of a stream
// out_o: decompressed bytes, and one status word (is_status set) per stream;
//   last_of_run marks the final word caused by one input byte
// cfg_i: one-bit swap_nibbles write, always ready, to be written between streams
// flag byte or reference first byte: no result, but the status word if final
// literal: byte shown in the output register the next cycle
// reference second byte, distance within the produced count: the copy state
//   reads len (3 to 18) bytes, one byte per cycle while the output register
//   is free, from the single read port of the 4096-byte history ram, each
//   written back and shown; input is accepted again once the copy is drained
// after a final literal or copy the status state emits the status word
// receiver stall: the output register holds its word, the copy pauses and no
//   input word is taken while the register is full and not being drained
// reset: stream state cleared, swap_nibbles 0; history contents undefined but
//   never read before written, as the produced count bounds every distance
`default_nettype none

module lzss_flag_byte_decoder_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  lzfd_in_if.sink     in_i,
  lzfd_out_if.source  out_o,
  lzfd_cfg_if.sink    cfg_i
);

  lzfd_pkg::dp_cmd_t  cmd;
  lzfd_pkg::dp_stat_t stat;
  logic               cfg_we;

  // configuration register lives in the datapath, writes never wait
  assign cfg_i.ready = 1'b1;
  assign cfg_we      = cfg_i.valid;

  // controller: token decode and copy sequencing
  lzfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.is_last),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // datapath: stream registers, history ram and the result register
  lzfd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_byte_i       (in_i.in_byte),
    .in_last_i       (in_i.is_last),
    .cfg_we_i        (cfg_we),
    .cfg_swap_i      (cfg_i.swap_nibbles),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_byte_o      (out_o.out_byte),
    .out_is_status_o (out_o.is_status),
    .out_status_o    (out_o.status),
    .out_last_o      (out_o.last_of_run)
  );

endmodule

`default_nettype wire
